// File: rtl/mtbc_pkg.sv
// mtbc_pkg: shared constants, codes and types for the markup tag balance checker
// used by every file of the block; depends on nothing

package mtbc_pkg;

   // sizes of the name stack and of one stored name
   localparam int STACK_DEPTH    = 32;
   localparam int MAX_NAME_BYTES = 8;
   localparam int NAME_W         = 8 * MAX_NAME_BYTES;
   localparam int LEN_W          = $clog2(MAX_NAME_BYTES + 2);
   localparam int LEVEL_W        = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_W        = 6;

   // characters the parser reacts to
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // error codes as reported on the result channel
   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_CLOSE_EMPTY = 3'd1,
      ERR_MISMATCH    = 3'd2,
      ERR_UNTERM      = 3'd3,
      ERR_EMPTY       = 3'd4,
      ERR_OPEN        = 3'd5,
      ERR_LONG        = 3'd6,
      ERR_OVERFLOW    = 3'd7
   } err_type;

   // one stack entry: name bytes (byte i in bits 8i+7..8i) and length
   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [LEN_W-1:0]  len;
   } entry_type;

   // shift control for the row of stack cells
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   // one result item
   typedef struct packed {
      logic               well_formed;
      err_type            error_kind;
      logic [DEPTH_W-1:0] open_depth;
   } result_type;

endpackage

// File: rtl/mtbc_cell.sv
// mtbc_cell: one cell of the shifting name stack
// depends on mtbc_pkg for the entry and shift control types

module mtbc_cell (
   input  logic                     clock,
   input  mtbc_pkg::stack_ctl_type  ctl,
   input  mtbc_pkg::entry_type      above,
   input  mtbc_pkg::entry_type      below,
   output mtbc_pkg::entry_type      entry
);

   mtbc_pkg::entry_type entry_ff;
   mtbc_pkg::entry_type entry_in;

   // push takes the neighbor nearer the top, pop the neighbor further down
   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         entry_in = above;
      end else if (ctl.pop) begin
         entry_in = below;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/mtbc_parse.sv
// mtbc_parse: byte parser, tag buffer, stack level and first-error tracking
// depends on mtbc_pkg; reads the top stack entry and drives the cell row shifts

module mtbc_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               char_byte,
   input  logic                     last,
   input  mtbc_pkg::entry_type      top_entry,
   output mtbc_pkg::stack_ctl_type  ctl,
   output mtbc_pkg::entry_type      push_entry,
   output logic                     result_valid,
   output mtbc_pkg::result_type     result
);

   typedef enum logic [1:0] {
      PH_OUT  = 2'd0,
      PH_LEAD = 2'd1,
      PH_BODY = 2'd2,
      PH_SKIP = 2'd3
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [mtbc_pkg::NAME_W-1:0]       tag_buf_ff, tag_buf_in;
   logic [mtbc_pkg::LEN_W-1:0]        tag_len_ff, tag_len_in;
   logic                              closing_ff, closing_in;
   mtbc_pkg::err_type                 err_ff, err_in;
   logic [mtbc_pkg::LEVEL_W-1:0]      level_ff, level_in;

   logic [mtbc_pkg::NAME_W-1:0]       app_buf;
   logic [mtbc_pkg::LEN_W-1:0]        app_len;
   logic                              is_blank;
   logic                              push, pop;
   mtbc_pkg::err_type                 err_out;
   logic [15:0]                       depth_wide;

   // byte lane write for the next name byte
   always_comb begin
      for (int i = 0; i < mtbc_pkg::MAX_NAME_BYTES; i++) begin
         app_buf[i*8 +: 8] = (tag_len_ff == mtbc_pkg::LEN_W'(i)) ? char_byte
                                                                 : tag_buf_ff[i*8 +: 8];
      end
      if (tag_len_ff < mtbc_pkg::LEN_W'(mtbc_pkg::MAX_NAME_BYTES)) begin
         app_len = tag_len_ff + mtbc_pkg::LEN_W'(1);
      end else begin
         app_len = mtbc_pkg::LEN_W'(mtbc_pkg::MAX_NAME_BYTES + 1);
      end
   end

   assign is_blank = (char_byte == mtbc_pkg::CH_SPACE) || (char_byte == mtbc_pkg::CH_TAB) ||
                     (char_byte == mtbc_pkg::CH_LF)    || (char_byte == mtbc_pkg::CH_CR);

   // next state for one byte; nothing moves once an error is latched
   always_comb begin
      phase_in   = phase_ff;
      tag_buf_in = tag_buf_ff;
      tag_len_in = tag_len_ff;
      closing_in = closing_ff;
      err_in     = err_ff;
      level_in   = level_ff;
      push       = 1'b0;
      pop        = 1'b0;
      if (err_ff == mtbc_pkg::ERR_NONE) begin
         unique case (phase_ff) inside
            PH_OUT: begin
               if (char_byte == mtbc_pkg::CH_LT) begin
                  phase_in = PH_LEAD;
               end
            end
            PH_LEAD: begin
               if (char_byte == mtbc_pkg::CH_GT) begin
                  err_in = mtbc_pkg::ERR_EMPTY;
               end else if (is_blank) begin
                  phase_in = PH_LEAD;
               end else if (char_byte == mtbc_pkg::CH_SLASH) begin
                  closing_in = 1'b1;
                  phase_in   = PH_BODY;
               end else begin
                  tag_buf_in = app_buf;
                  tag_len_in = app_len;
                  phase_in   = PH_BODY;
               end
            end
            PH_BODY, PH_SKIP: begin
               if (char_byte == mtbc_pkg::CH_GT) begin
                  // tag complete: push, pop or flag
                  if (closing_ff) begin
                     if (tag_len_ff == '0) begin
                        err_in = mtbc_pkg::ERR_EMPTY;
                     end else if (level_ff == '0) begin
                        err_in = mtbc_pkg::ERR_CLOSE_EMPTY;
                     end else if (tag_len_ff > mtbc_pkg::LEN_W'(mtbc_pkg::MAX_NAME_BYTES) ||
                                  top_entry.len != tag_len_ff ||
                                  top_entry.name != tag_buf_ff) begin
                        err_in = mtbc_pkg::ERR_MISMATCH;
                     end else begin
                        pop      = 1'b1;
                        level_in = level_ff - mtbc_pkg::LEVEL_W'(1);
                     end
                  end else begin
                     if (tag_len_ff > mtbc_pkg::LEN_W'(mtbc_pkg::MAX_NAME_BYTES)) begin
                        err_in = mtbc_pkg::ERR_LONG;
                     end else if (level_ff >= mtbc_pkg::LEVEL_W'(mtbc_pkg::STACK_DEPTH)) begin
                        err_in = mtbc_pkg::ERR_OVERFLOW;
                     end else begin
                        push     = 1'b1;
                        level_in = level_ff + mtbc_pkg::LEVEL_W'(1);
                     end
                  end
                  tag_buf_in = '0;
                  tag_len_in = '0;
                  closing_in = 1'b0;
                  phase_in   = PH_OUT;
               end else if (phase_ff == PH_BODY) begin
                  if (!closing_ff && char_byte == mtbc_pkg::CH_SPACE) begin
                     phase_in = PH_SKIP;
                  end else begin
                     tag_buf_in = app_buf;
                     tag_len_in = app_len;
                  end
               end
            end
            default: begin
               phase_in = PH_OUT;
            end
         endcase
      end
   end

   // result seen after this byte, with the end-of-document checks
   always_comb begin
      err_out = err_in;
      if (err_in == mtbc_pkg::ERR_NONE) begin
         if (phase_in != PH_OUT) begin
            err_out = mtbc_pkg::ERR_UNTERM;
         end else if (level_in != '0) begin
            err_out = mtbc_pkg::ERR_OPEN;
         end
      end
      depth_wide         = 16'(level_in);
      result.well_formed = (err_out == mtbc_pkg::ERR_NONE);
      result.error_kind  = err_out;
      result.open_depth  = (depth_wide > 16'd63) ? {mtbc_pkg::DEPTH_W{1'b1}}
                                                 : mtbc_pkg::DEPTH_W'(depth_wide);
   end

   assign result_valid    = accept && last;
   assign ctl.push        = accept && push;
   assign ctl.pop         = accept && pop;
   assign push_entry.name = tag_buf_ff;
   assign push_entry.len  = tag_len_ff;

   // parser state; a last byte returns everything to its start
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OUT;
         tag_buf_ff <= '0;
         tag_len_ff <= '0;
         closing_ff <= 1'b0;
         err_ff     <= mtbc_pkg::ERR_NONE;
         level_ff   <= '0;
      end else if (accept) begin
         if (last) begin
            phase_ff   <= PH_OUT;
            tag_buf_ff <= '0;
            tag_len_ff <= '0;
            closing_ff <= 1'b0;
            err_ff     <= mtbc_pkg::ERR_NONE;
            level_ff   <= '0;
         end else begin
            phase_ff   <= phase_in;
            tag_buf_ff <= tag_buf_in;
            tag_len_ff <= tag_len_in;
            closing_ff <= closing_in;
            err_ff     <= err_in;
            level_ff   <= level_in;
         end
      end
   end

endmodule

// File: rtl/markup_tag_balance_checker.sv
// markup_tag_balance_checker: top level of the tag nesting checker
// depends on mtbc_pkg, mtbc_parse and mtbc_cell

// The block takes one document byte per clock cycle while req_stall is low and
// gives one result item for each byte marked last, from a registered output. The name
// stack is a row of STACK_DEPTH cells that all shift one place on a push or a
// pop, so the top name always sits in the first cell and a closing tag is
// checked against it in the same cycle as its '>' byte. A two-entry result
// buffer lets bytes keep flowing while a result waits; the input stalls only
// when two results are waiting. No clearing pass follows reset: the stack
// contents are only read below the current level.

module markup_tag_balance_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_well_formed,
   output logic [2:0]  rsp_error_kind,
   output logic [5:0]  rsp_open_depth
);

   logic                     req_accept;
   logic                     rsp_accept;
   mtbc_pkg::stack_ctl_type  ctl;
   mtbc_pkg::entry_type      push_entry;
   mtbc_pkg::entry_type      cell_q [mtbc_pkg::STACK_DEPTH];
   logic                     result_valid;
   mtbc_pkg::result_type     result;
   mtbc_pkg::result_type     slot0_ff, slot0_in;
   mtbc_pkg::result_type     slot1_ff, slot1_in;
   logic [1:0]               count_ff, count_in;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (count_ff == 2'd2);

   // parser and stack control
   mtbc_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .char_byte    (req_char_byte),
      .last         (req_last),
      .top_entry    (cell_q[0]),
      .ctl          (ctl),
      .push_entry   (push_entry),
      .result_valid (result_valid),
      .result       (result)
   );

   // row of stack cells, top at index 0
   for (genvar g = 0; g < mtbc_pkg::STACK_DEPTH; g++) begin : g_cell
      mtbc_pkg::entry_type above;
      mtbc_pkg::entry_type below;
      if (g == 0) begin : g_top
         assign above = push_entry;
      end else begin : g_mid
         assign above = cell_q[g-1];
      end
      if (g == mtbc_pkg::STACK_DEPTH - 1) begin : g_end
         assign below = cell_q[g];
      end else begin : g_inner
         assign below = cell_q[g+1];
      end
      mtbc_cell u_cell (
         .clock (clock),
         .ctl   (ctl),
         .above (above),
         .below (below),
         .entry (cell_q[g])
      );
   end

   // two-entry result buffer, slot0 faces the output
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (rsp_accept) begin
         if (count_ff == 2'd2) begin
            slot0_in = slot1_ff;
         end else if (result_valid) begin
            slot0_in = result;
         end
      end else if (result_valid) begin
         if (count_ff == 2'd0) begin
            slot0_in = result;
         end else begin
            slot1_in = result;
         end
      end
      count_in = count_ff + {1'b0, result_valid} - {1'b0, rsp_accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_well_formed = slot0_ff.well_formed;
   assign rsp_error_kind  = slot0_ff.error_kind;
   assign rsp_open_depth  = slot0_ff.open_depth;

endmodule

// File: rtl/mtbc_checker.sv
// mtbc_checker: port-level assertions for the tag nesting checker
// depends on mtbc_pkg; bound to markup_tag_balance_checker below

module mtbc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_well_formed,
   input  logic [2:0]  rsp_error_kind,
   input  logic [5:0]  rsp_open_depth
);

   // well_formed agrees with the error code
   a_wf_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_well_formed == (rsp_error_kind == mtbc_pkg::ERR_NONE)))
      else $error("well_formed disagrees with error_kind");

   // a well formed document leaves no tag open
   a_wf_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_well_formed |-> rsp_open_depth == '0)
      else $error("well formed item with open tags");

   // tags left open means a nonzero depth, close on empty means zero depth
   a_open_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_kind == mtbc_pkg::ERR_OPEN |-> rsp_open_depth != '0)
      else $error("left open reported with zero depth");

   a_close_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_kind == mtbc_pkg::ERR_CLOSE_EMPTY |-> rsp_open_depth == '0)
      else $error("close on empty reported with open tags");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_well_formed) &&
                                 $stable(rsp_error_kind) && $stable(rsp_open_depth))
      else $error("stalled result item changed");

endmodule

bind markup_tag_balance_checker mtbc_checker u_mtbc_checker (.*);
